// ----- sv/assert_macros.svh -----
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge, off during reset.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked on the rising clock edge, off during reset.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// ----- sv/uvas_pkg.sv -----
`timescale 1ns / 1ps

package uvas_pkg;

  // Field widths and default store size
  localparam int unsigned DEF_CAPACITY = 128;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned FILL_W       = 8;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Input word
  typedef struct packed {
    logic                       action;
    logic signed [VALUE_W-1:0]  value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [FILL_W-1:0]   fill_count;
  } out_word_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_e;

  // Datapath commands
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_NEXT,
    DP_INSERT,
    DP_DUP,
    DP_FULL,
    DP_NOTFOUND,
    DP_DELETE,
    DP_SHIFT
  } dp_op_e;

  // Datapath status back to the controller
  typedef struct packed {
    logic match;
    logic more;
    logic full;
    logic is_delete;
  } dp_stat_t;

endpackage

// ----- sv/uvas_ram.sv -----
`timescale 1ns / 1ps

module uvas_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/uvas_ctrl.sv -----
`timescale 1ns / 1ps

module uvas_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  uvas_pkg::dp_stat_t stat_i,
  output uvas_pkg::dp_op_e  op_o,
  output logic              busy_o,
  output logic              done_o
);

  import uvas_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          state_d = (stat_i.is_delete && stat_i.more) ? S_SHIFT : S_RESP;
        end else if (!stat_i.more) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (!stat_i.more) state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op_o   = DP_NONE;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) op_o = DP_LOAD;
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          op_o = stat_i.is_delete ? DP_DELETE : DP_DUP;
        end else if (stat_i.more) begin
          op_o = DP_NEXT;
        end else if (stat_i.is_delete) begin
          op_o = DP_NOTFOUND;
        end else if (stat_i.full) begin
          op_o = DP_FULL;
        end else begin
          op_o = DP_INSERT;
        end
      end
      S_SHIFT: begin
        op_o = DP_SHIFT;
      end
      S_RESP: begin
        done_o = 1'b1;
      end
      default: begin
        op_o = DP_NONE;
      end
    endcase
  end

endmodule

// ----- sv/uvas_dp.sv -----
`timescale 1ns / 1ps

module uvas_dp #(
  parameter int unsigned CAPACITY = uvas_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uvas_pkg::dp_op_e    op_i,
  input  uvas_pkg::in_word_t  cmd_i,
  output uvas_pkg::dp_stat_t  stat_o,
  output uvas_pkg::out_word_t rsp_o
);

  import uvas_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic               action_q, action_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  status_e            status_q, status_d;
  logic [POS_W-1:0]   pos_q, pos_d;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [VALUE_W-1:0] wdata;
  logic [IDX_W-1:0]   raddr;
  logic [VALUE_W-1:0] rdata;
  logic [CNT_W-1:0]   idx_ext;

  // Value store
  uvas_ram #(
    .WIDTH  (VALUE_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    value_q  <= value_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  // Decode command
  always_comb begin
    action_d = action_q;
    value_d  = value_q;
    idx_d    = idx_q;
    count_d  = count_q;
    status_d = status_q;
    pos_d    = pos_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = value_q;
    raddr    = idx_q + IDX_W'(1);
    case (op_i)
      DP_LOAD: begin
        action_d = cmd_i.action;
        value_d  = cmd_i.value;
        idx_d    = '0;
        raddr    = '0;
      end
      DP_NEXT: begin
        idx_d = idx_q + IDX_W'(1);
      end
      DP_INSERT: begin
        we       = 1'b1;
        waddr    = IDX_W'(count_q);
        status_d = ST_INSERTED;
        pos_d    = POS_W'(count_q);
        count_d  = count_q + CNT_W'(1);
      end
      DP_DUP: begin
        status_d = ST_DUPLICATE;
        pos_d    = POS_W'(idx_q);
      end
      DP_FULL: begin
        status_d = ST_FULL;
        pos_d    = '0;
      end
      DP_NOTFOUND: begin
        status_d = ST_NOT_FOUND;
        pos_d    = '0;
      end
      DP_DELETE: begin
        // Read the entry above the hit for the first shift move
        status_d = ST_DELETED;
        pos_d    = POS_W'(idx_q);
        count_d  = count_q - CNT_W'(1);
      end
      DP_SHIFT: begin
        // Move the fetched entry down one slot and fetch the next one
        we    = 1'b1;
        waddr = idx_q;
        wdata = rdata;
        idx_d = idx_q + IDX_W'(1);
        raddr = idx_q + IDX_W'(2);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Status flags; during a shift the count is already one lower
  assign idx_ext          = CNT_W'(idx_q);
  assign stat_o.match     = (idx_ext < count_q) && (rdata == value_q);
  assign stat_o.more      = (idx_ext + CNT_W'(1)) < count_q;
  assign stat_o.full      = count_q >= CNT_W'(CAPACITY);
  assign stat_o.is_delete = action_q;

  // Result word
  assign rsp_o.status     = status_q;
  assign rsp_o.position   = pos_q;
  assign rsp_o.fill_count = FILL_W'(count_q);

endmodule

// ----- sv/unique_value_array_set.sv -----
`timescale 1ns / 1ps

// Channel   Ports                         Transfer
// -------   ---------------------------   ---------------------------------
// command   start, busy, cmd_i            word taken when start & !busy
// result    done_o, rsp_o                 word valid for the one cycle of done_o
//
// Each word searches n entries, where n is at least one, then raises done_o and returns to idle.
// A delete also moves each entry above the hit down one slot, but stops searching at the hit,
// so searched plus moved entries never exceed the fill count. The single read port of the
// store limits the walk to one entry compared or moved per cycle.
// Reset clears the fill count; store contents stay undefined and are never read
// beyond the count. Results cannot be stalled; busy stays high until done_o.

module unique_value_array_set #(
  parameter int unsigned CAPACITY = uvas_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  uvas_pkg::in_word_t  cmd_i,
  output logic                done_o,
  output uvas_pkg::out_word_t rsp_o
);

  import uvas_pkg::*;

`include "assert_macros.svh"

  dp_op_e           op;
  dp_stat_t         stat;
  logic             rsp_ins;
  logic             rsp_miss;
  logic [POS_W-1:0] ins_pos;

  uvas_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  uvas_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .cmd_i  (cmd_i),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

  // Classify the result word for the checks below
  assign rsp_ins  = done_o && (rsp_o.status == ST_INSERTED);
  assign rsp_miss = done_o && (rsp_o.status == ST_NOT_FOUND || rsp_o.status == ST_FULL);
  assign ins_pos  = POS_W'(rsp_o.fill_count - FILL_W'(1));

  // A taken word keeps the block busy; a result frees it
  `ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_NXT(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // An insert lands at the old fill count
  `ASSERT_IMP(a_ins_pos, clk_i, rst_ni, rsp_ins, rsp_o.position == ins_pos)
  // A miss reports position zero
  `ASSERT_IMP(a_miss_pos, clk_i, rst_ni, rsp_miss, rsp_o.position == '0)

endmodule
